[rtl/ttuv_pkg.sv]
// Package for the per-triangle tangent unit: payload structs, constants,
// controller/datapath command and status types. No dependencies.
package ttuv_pkg;

  localparam int unsigned TanFracBits = 15;
  localparam logic [15:0] TanCap = (TanFracBits >= 15) ? 16'd32767
                                   : 16'((32'd1 << TanFracBits) - 1);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [19:0] tex_u;
    logic signed [19:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               degenerate;
  } tan_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_TAN, ST_MAX, ST_NORM, ST_SQ, ST_SQRT,
    ST_ROOT, ST_DIV, ST_OUT
  } state_e;

  typedef struct packed {
    logic load0;
    logic load1;
    logic load2;
    logic mul1;
    logic mul2;
    logic tan;
    logic maxc;
    logic norm;
    logic sq;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic sqrt_done;
    logic div_done;
  } sts_t;

endpackage

[rtl/triangle_tangent_from_uv_unit.sv]
// Top level of the per-triangle tangent unit; instantiates ttuv_ctrl and
// ttuv_datapath. Uses ttuv_pkg.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i) takes one vertex per
//    transfer. Vertices group in threes; the first two are held, the third
//    completes a triangle and yields exactly one result transfer.
//  - Output channel (out_valid_o/out_ready_i/out_data_o) carries the unit
//    tangent in Q1.15 and a degenerate flag (tangent zero when set).
//  - First and second vertex: each is taken and held. Third vertex: the
//    differences, products, max and normalization, the square root (33
//    steps plus hand-off), then three restoring divisions plus a closing
//    step. The result is loaded into the output register and the unit
//    returns to idle, ready for the next vertex; it takes no vertex while
//    it works through a triangle. Degenerate triangles skip root and
//    divide and go straight to the output load.
//  - The result sits in an output register; while the receiver stalls, the
//    unit still takes the next two vertices, works through the third and
//    then waits to load, taking no new vertex.
//  - Reset clears the corner count and the output valid; held vertices are
//    overwritten before use.
module triangle_tangent_from_uv_unit import ttuv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  vtx_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output tan_t out_data_o
);

  cmd_t cmd;
  sts_t sts;
  logic out_set;
  logic out_valid_q;

  ttuv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_valid_i && in_ready_o),
    .out_free_i (!out_valid_q || out_ready_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .out_set_o  (out_set),
    .cmd_o      (cmd)
  );

  ttuv_datapath u_dp (
    .clk_i (clk_i),
    .vtx_i (in_data_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_set) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end
  assign out_valid_o = out_valid_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.tangent_x == 16'sd0)
    else $error("degenerate result with nonzero tangent");
  a_set_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_set |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over pending transfer");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_set |-> !in_ready_o)
    else $error("input taken while loading result");

endmodule

[rtl/ttuv_datapath.sv]
// Datapath of the tangent unit: vertex holding registers, products,
// normalization, iterative square root and divider. Uses ttuv_pkg.
module ttuv_datapath import ttuv_pkg::*; (
  input  logic clk_i,
  input  vtx_t vtx_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output tan_t res_o
);

  logic signed [31:0] p0_q [3];
  logic signed [31:0] p1_q [3];
  logic signed [19:0] t0_q [2];
  logic signed [19:0] t1_q [2];
  logic signed [32:0] e1_q [3];
  logic signed [32:0] e2_q [3];
  logic signed [20:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [41:0] pa_q, pb_q;
  logic signed [54:0] ta_q [3];
  logic signed [54:0] tb_q [3];
  logic signed [55:0] t_q [3];
  logic               neg_q [3];
  logic [55:0]        mg_q [3];
  logic [55:0]        m_q;
  logic               det_zero_q, det_neg_q;
  logic [63:0]        s_q, rem_q, root_q, bit_q;
  logic [5:0]         dcnt_q;
  logic [1:0]         dsel_q;
  logic [46:0]        num_q;
  logic [46:0]        dquo_q;
  logic [46:0]        drem_q;
  logic [15:0]        q_q [3];

  logic [5:0] lz;
  always_comb begin
    lz = 6'd0;
    for (int i = 55; i >= 0; i--) begin
      if (m_q[i] && lz == 6'd0) lz = 6'(56 - i);
    end
  end

  // squares of the normalized magnitudes (each below 2^30)
  logic [59:0] sq0, sq1, sq2;
  assign sq0 = mg_q[0][29:0] * mg_q[0][29:0];
  assign sq1 = mg_q[1][29:0] * mg_q[1][29:0];
  assign sq2 = mg_q[2][29:0] * mg_q[2][29:0];

  logic [47:0] dtrial;
  assign dtrial = {drem_q, num_q[46]} - {16'd0, root_q[31:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load0) begin
      p0_q[0] <= vtx_i.pos_x; p0_q[1] <= vtx_i.pos_y; p0_q[2] <= vtx_i.pos_z;
      t0_q[0] <= vtx_i.tex_u; t0_q[1] <= vtx_i.tex_v;
    end
    if (cmd_i.load1) begin
      p1_q[0] <= vtx_i.pos_x; p1_q[1] <= vtx_i.pos_y; p1_q[2] <= vtx_i.pos_z;
      t1_q[0] <= vtx_i.tex_u; t1_q[1] <= vtx_i.tex_v;
    end
    if (cmd_i.load2) begin
      e1_q[0] <= 33'(p1_q[0]) - 33'(p0_q[0]);
      e1_q[1] <= 33'(p1_q[1]) - 33'(p0_q[1]);
      e1_q[2] <= 33'(p1_q[2]) - 33'(p0_q[2]);
      e2_q[0] <= 33'(vtx_i.pos_x) - 33'(p0_q[0]);
      e2_q[1] <= 33'(vtx_i.pos_y) - 33'(p0_q[1]);
      e2_q[2] <= 33'(vtx_i.pos_z) - 33'(p0_q[2]);
      d1u_q <= 21'(t1_q[0]) - 21'(t0_q[0]);
      d1v_q <= 21'(t1_q[1]) - 21'(t0_q[1]);
      d2u_q <= 21'(vtx_i.tex_u) - 21'(t0_q[0]);
      d2v_q <= 21'(vtx_i.tex_v) - 21'(t0_q[1]);
    end
    if (cmd_i.mul1) begin
      pa_q <= d1u_q * d2v_q;
      pb_q <= d2u_q * d1v_q;
      for (int i = 0; i < 3; i++) ta_q[i] <= d2v_q * e1_q[i];
    end
    if (cmd_i.mul2) begin
      det_zero_q <= (pa_q == pb_q);
      det_neg_q  <= (pa_q < pb_q);
      for (int i = 0; i < 3; i++) tb_q[i] <= d1v_q * e2_q[i];
    end
    if (cmd_i.tan) begin
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= det_neg_q ? 56'(tb_q[i]) - 56'(ta_q[i])
                            : 56'(ta_q[i]) - 56'(tb_q[i]);
      end
    end
    if (cmd_i.maxc) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= t_q[i][55];
        mg_q[i]  <= t_q[i][55] ? 56'(-t_q[i]) : 56'(t_q[i]);
      end
    end
    if (cmd_i.sq) begin
      // largest magnitude, sets the common shift
      m_q <= (mg_q[0] > mg_q[1]) ? ((mg_q[0] > mg_q[2]) ? mg_q[0] : mg_q[2])
                                 : ((mg_q[1] > mg_q[2]) ? mg_q[1] : mg_q[2]);
    end
    if (cmd_i.norm) begin
      // lz: 56 - msb index; want msb at 29 -> shift left by (lz - 27)
      for (int i = 0; i < 3; i++) begin
        if (lz >= 6'd27) mg_q[i] <= mg_q[i] << (lz - 6'd27);
        else             mg_q[i] <= mg_q[i] >> (6'd27 - lz);
      end
    end
    if (cmd_i.sqrt_init) begin
      s_q    <= 64'(sq0) + 64'(sq1) + 64'(sq2);
      rem_q  <= 64'd0;
      root_q <= 64'd0;
      bit_q  <= 64'd1 << 62;
    end
    if (cmd_i.sqrt_step) begin
      if (rem_q + 64'd0 == 64'd0 && s_q != 64'd0) begin
        rem_q <= s_q; s_q <= 64'd0;
      end else if (bit_q != 64'd0) begin
        if (rem_q >= root_q + bit_q) begin
          rem_q  <= rem_q - (root_q + bit_q);
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
    if (cmd_i.div_init) begin
      dsel_q <= 2'd0;
      dcnt_q <= 6'd47;
      num_q  <= (47'(mg_q[0][29:0]) << TanFracBits) + 47'(root_q[31:1]);
      drem_q <= 47'd0;
      dquo_q <= 47'd0;
    end
    if (cmd_i.div_step) begin
      if (dcnt_q != 6'd0) begin
        if (!dtrial[47]) begin
          drem_q <= dtrial[46:0];
          dquo_q <= {dquo_q[45:0], 1'b1};
        end else begin
          drem_q <= {drem_q[45:0], num_q[46]};
          dquo_q <= {dquo_q[45:0], 1'b0};
        end
        num_q  <= num_q << 1;
        dcnt_q <= dcnt_q - 6'd1;
      end else begin
        q_q[dsel_q] <= (dquo_q > 47'(TanCap)) ? TanCap : dquo_q[15:0];
        dsel_q <= dsel_q + 2'd1;
        dcnt_q <= 6'd47;
        num_q  <= (47'((dsel_q == 2'd0 ? mg_q[1][29:0] : mg_q[2][29:0])) << TanFracBits)
                  + 47'(root_q[31:1]);
        drem_q <= 47'd0;
        dquo_q <= 47'd0;
      end
    end
    if (cmd_i.out_load) begin
      res_o.degenerate <= sts_o.degen;
      res_o.tangent_x  <= sts_o.degen ? 16'sd0 : (neg_q[0] ? -q_q[0] : q_q[0]);
      res_o.tangent_y  <= sts_o.degen ? 16'sd0 : (neg_q[1] ? -q_q[1] : q_q[1]);
      res_o.tangent_z  <= sts_o.degen ? 16'sd0 : (neg_q[2] ? -q_q[2] : q_q[2]);
    end
  end

  assign sts_o.degen     = det_zero_q || (m_q == 56'd0);
  assign sts_o.sqrt_done = (bit_q == 64'd0) && (s_q == 64'd0);
  // all three quotients stored
  assign sts_o.div_done  = (dsel_q == 2'd3);

endmodule

[rtl/ttuv_ctrl.sv]
// Controller of the tangent unit: corner counter and sequencing FSM.
// Uses ttuv_pkg.
module ttuv_ctrl import ttuv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  logic out_free_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output logic out_set_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic [1:0] corner_q, corner_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      corner_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    corner_d   = corner_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_set_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          case (corner_q)
            2'd1: begin cmd_o.load1 = 1'b1; corner_d = 2'd2; end
            2'd2: begin cmd_o.load2 = 1'b1; corner_d = 2'd0; state_d = ST_MUL1; end
            default: begin cmd_o.load0 = 1'b1; corner_d = 2'd1; end
          endcase
        end
      end
      ST_MUL1: begin cmd_o.mul1 = 1'b1; state_d = ST_MUL2; end
      ST_MUL2: begin cmd_o.mul2 = 1'b1; state_d = ST_TAN; end
      ST_TAN:  begin cmd_o.tan  = 1'b1; state_d = ST_MAX; end
      ST_MAX:  begin cmd_o.maxc = 1'b1; state_d = ST_SQ; end
      ST_SQ:   begin cmd_o.sq   = 1'b1; state_d = ST_NORM; end
      ST_NORM: begin
        if (sts_i.degen) state_d = ST_OUT;
        else begin cmd_o.norm = 1'b1; state_d = ST_SQRT; end
      end
      ST_SQRT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sts_i.sqrt_done) cmd_o.sqrt_step = 1'b1;
        else begin
          cmd_o.div_init = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_done) cmd_o.div_step = 1'b1;
        else state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          out_set_o = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for triangle_tangent_from_uv_unit: directed vertex
// table, then random triangles checked against an in-bench tangent predictor.
// Depends on ttuv_pkg and the RTL top level.
module tb_top;
  import ttuv_pkg::*;

  localparam int unsigned NumRandom = 1850;
  localparam int unsigned IdleLimit = 20000;

  // Directed rows: vertex plus an optional typed-in expectation
  typedef struct {
    vtx_t vtx;
    bit   has_exp;
    tan_t exp;
  } vertex_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  vtx_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  tan_t out_data_o;

  triangle_tangent_from_uv_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: first two corners of the current triangle
  vtx_t corner_q[2];
  int   corner_idx = 0;
  tan_t tangent_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   tri_count = 0;
  int   degen_count = 0;
  bit   stim_done = 0;
  bit   long_hold = 0;
  // typed-in expectation for the triangle closed by the vertex being sent
  bit   typed_has = 0;
  tan_t typed_val = '0;

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic tan_t tangent_of(vtx_t a, vtx_t b, vtx_t c);
    longint e1[3], e2[3], t[3];
    longint unsigned mg[3], m, s, len, q;
    longint d1u, d1v, d2u, d2v, det;
    int sh;
    tan_t r;
    e1[0] = longint'(b.pos_x) - longint'(a.pos_x);
    e1[1] = longint'(b.pos_y) - longint'(a.pos_y);
    e1[2] = longint'(b.pos_z) - longint'(a.pos_z);
    e2[0] = longint'(c.pos_x) - longint'(a.pos_x);
    e2[1] = longint'(c.pos_y) - longint'(a.pos_y);
    e2[2] = longint'(c.pos_z) - longint'(a.pos_z);
    d1u = longint'(b.tex_u) - longint'(a.tex_u);
    d1v = longint'(b.tex_v) - longint'(a.tex_v);
    d2u = longint'(c.tex_u) - longint'(a.tex_u);
    d2v = longint'(c.tex_v) - longint'(a.tex_v);
    det = d1u * d2v - d2u * d1v;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = d2v * e1[i] - d1v * e2[i];
      if (det < 0) t[i] = -t[i];
      mg[i] = (t[i] < 0) ? -t[i] : t[i];
      if (mg[i] > m) m = mg[i];
    end
    r = '0;
    if (det == 0 || m == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // bring the largest magnitude into [2^29, 2^30)
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    if (sh > 0) begin
      for (int i = 0; i < 3; i++) mg[i] >>= sh;
    end else begin
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        sh++;
      end
      for (int i = 0; i < 3; i++) mg[i] <<= sh;
    end
    s = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    len = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << TanFracBits) + (len >> 1)) / len;
      if (q > TanCap) q = TanCap;
      if (t[i] < 0) q = -q;
      case (i)
        0: r.tangent_x = q[15:0];
        1: r.tangent_y = q[15:0];
        default: r.tangent_z = q[15:0];
      endcase
    end
    return r;
  endfunction

  // Runs on every accepted vertex; queues a tangent on each third corner
  task automatic note_vertex(vtx_t v);
    if (corner_idx < 2) begin
      corner_q[corner_idx] = v;
      corner_idx++;
    end else begin
      if (typed_has) tangent_q = {tangent_q, typed_val};
      else tangent_q = {tangent_q, tangent_of(corner_q[0], corner_q[1], v)};
      corner_idx = 0;
    end
  endtask

  function automatic vtx_t mk_vtx(int x, int y, int z, int u, int v);
    vtx_t r;
    r.pos_x = x; r.pos_y = y; r.pos_z = z;
    r.tex_u = u[19:0]; r.tex_v = v[19:0];
    return r;
  endfunction

  function automatic vtx_t rand_vtx(bit full_range);
    vtx_t r;
    if (full_range) begin
      r = {$urandom, $urandom, $urandom, 20'($urandom), 20'($urandom)};
    end else begin
      r.pos_x = $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
      r.pos_y = $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
      r.pos_z = $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
      r.tex_u = 20'($urandom_range(0, 2 ** 17));
      r.tex_v = 20'($urandom_range(0, 2 ** 17));
    end
    return r;
  endfunction

  // Sender: holds valid and payload until the transfer happens
  task automatic send_vertex(vtx_t v);
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    note_vertex(v);
  endtask

  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Directed table: extremes, degenerate cases, saturation on a pure axis
  vertex_row_t dir_rows[$];

  task automatic add_tri(vtx_t a, vtx_t b, vtx_t c, bit has, tan_t e);
    vertex_row_t r;
    r.has_exp = 0; r.exp = '0;
    r.vtx = a; dir_rows = {dir_rows, r};
    r.vtx = b; dir_rows = {dir_rows, r};
    r.vtx = c; r.has_exp = has; r.exp = e; dir_rows = {dir_rows, r};
  endtask

  initial begin
    tan_t degen_t, x_axis, none;
    vtx_t v;
    degen_t = '0; degen_t.degenerate = 1'b1;
    x_axis = '0; x_axis.tangent_x = TanCap;
    none = '0;
    // all zero: det zero
    add_tri(mk_vtx(0, 0, 0, 0, 0), mk_vtx(0, 0, 0, 0, 0), mk_vtx(0, 0, 0, 0, 0), 1, degen_t);
    // unit right triangle, u along x: tangent +x
    add_tri(mk_vtx(0, 0, 0, 0, 0), mk_vtx(65536, 0, 0, 65536, 0),
            mk_vtx(0, 65536, 0, 0, 65536), 1, x_axis);
    // collinear UVs: det zero
    add_tri(mk_vtx(0, 0, 0, 0, 0), mk_vtx(100, 5, 0, 10, 10),
            mk_vtx(7, 9, 3, 20, 20), 1, degen_t);
    // nonzero det, all positions equal: zero raw tangent
    add_tri(mk_vtx(5, 5, 5, 0, 0), mk_vtx(5, 5, 5, 65536, 0),
            mk_vtx(5, 5, 5, 0, 65536), 1, degen_t);
    // mirrored UV (negative det): still +x
    add_tri(mk_vtx(0, 0, 0, 0, 0), mk_vtx(65536, 0, 0, 65536, 0),
            mk_vtx(0, 65536, 0, 0, -65536), 1, x_axis);
    // position and texcoord extremes
    add_tri(mk_vtx(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, -524288, 524287),
            mk_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 524287, -524288),
            mk_vtx(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 524287, 524287), 0, none);
    add_tri(mk_vtx(-1, -1, -1, -1, -1), mk_vtx(1, 0, 0, 1, 0),
            mk_vtx(0, 1, 0, 0, 1), 0, none);
    v = mk_vtx(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 524287, 524287);
    add_tri(mk_vtx(0, 0, 0, -524288, -524288), v, mk_vtx(-7, 3, 32'h8000_0000, 0, 524287),
            0, none);
  end

  // Stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      typed_has = dir_rows[i].has_exp;
      typed_val = dir_rows[i].exp;
      send_vertex(dir_rows[i].vtx);
      sender_gap();
    end
    typed_has = 0;
    // Random: mostly well-formed triangles, some full-range noise
    for (int n = 0; n < NumRandom; n++) begin
      vtx_t v;
      v = rand_vtx($urandom_range(0, 3) == 0);
      // occasionally repeat a held corner to hit degenerate paths
      if (corner_idx > 0 && $urandom_range(0, 15) == 0) v = corner_q[0];
      send_vertex(v);
      sender_gap();
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // Receiver with random stalls; one long hold-off while the sender pushes on
  initial begin
    int n;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold && tri_count == 40) begin
        long_hold = 1;
        out_ready_i <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 5);
      out_ready_i <= (n == 0);
      if (n > 0) repeat (n) @(posedge clk_i);
      else @(posedge clk_i);
    end
  end

  // Checker: compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tan_t e, got;
      got = out_data_o;
      if (tangent_q.size() == 0) begin
        $error("result with no tangent pending: %h", got);
        errors++;
      end else begin
        e = tangent_q.pop_front();
        if (got.tangent_x !== e.tangent_x) begin
          $error("tangent_x exp %0d got %0d", e.tangent_x, got.tangent_x); errors++;
        end
        if (got.tangent_y !== e.tangent_y) begin
          $error("tangent_y exp %0d got %0d", e.tangent_y, got.tangent_y); errors++;
        end
        if (got.tangent_z !== e.tangent_z) begin
          $error("tangent_z exp %0d got %0d", e.tangent_z, got.tangent_z); errors++;
        end
        if (got.degenerate !== e.degenerate) begin
          $error("degenerate exp %0d got %0d", e.degenerate, got.degenerate); errors++;
        end
        if (e.degenerate) degen_count++;
      end
      tri_count++;
    end
  end

  // Watchdog and end of run
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("triangle_tangent_from_uv_unit: mismatch");
        $finish;
      end
      if (stim_done && tangent_q.size() == 0) begin
        repeat (300) @(posedge clk_i);
        $display("Covered %0d triangles (%0d degenerate) with random stalls on both sides.",
                 tri_count, degen_count);
        if (errors == 0 && tangent_q.size() == 0) begin
          $display("triangle_tangent_from_uv_unit: match");
        end else begin
          $display("triangle_tangent_from_uv_unit: mismatch");
        end
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/ttuv_pkg.sv
rtl/ttuv_datapath.sv
rtl/ttuv_ctrl.sv
rtl/triangle_tangent_from_uv_unit.sv
tb/tb_top.sv
